### src/gcr_pkg.sv
// Package for the gamma correction block: pixel transfer types, fixed widths and constants.
// Also holds the elaboration-time functions that build the log2 and exp2 lookup tables.
// No dependencies; every other file of the block imports it.
package gcr_pkg;

    // Channel width and input fraction (input channels are U4.12, results U0.16).
    localparam int CHANNEL_BITS = 16;
    localparam int FRAC_IN      = CHANNEL_BITS - 4;

    // Exponent register, U4.12, reset to about 1/2.2.
    localparam int                    GAMMA_BITS  = 16;
    localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 16'd1862;

    // Cycles from the accepting edge to the edge that ends the result strobe.
    localparam int GCR_LATENCY = 8;

    // One input pixel.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } pixel_in_t;

    // One corrected pixel.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
    } pixel_out_t;

    // 16-bit fraction of log2 of a Q1.30 mantissa in [1,2), by repeated squaring.
    function automatic logic [15:0] log_frac(input logic [63:0] m_in);
        logic [63:0] m;
        logic [15:0] r;
        m = m_in;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= 64'h0000_0000_8000_0000) begin
                r[b] = 1'b1;
                m    = m >> 1;
            end
        end
        return r;
    endfunction

    // Log table entry: floor(65536*log2(1+i/2^a)), with the last entry at exactly 1.0.
    function automatic logic [16:0] lg_entry(input int i, input int a);
        logic [63:0] mant;
        if (i >= (1 << a)) begin
            return 17'd65536;
        end
        mant = 64'((1 << a) + i) << (30 - a);
        return {1'b0, log_frac(mant)};
    endfunction

    // Exp table entry: smallest Q1.16 mantissa whose log reaches i*2^(16-a).
    function automatic logic [17:0] ex_entry(input int i, input int a);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        logic [31:0] target;
        if (i >= (1 << a)) begin
            return 18'd131072;
        end
        target = 32'(i) << (16 - a);
        lo     = 32'd65536;
        hi     = 32'd131072;
        for (int k = 0; k < 20; k++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (32'(log_frac(64'(mid) << 14)) >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 32'd1;
                end
            end
        end
        return lo[17:0];
    endfunction

endpackage

### src/gcr_lane.sv
// One channel lane of the gamma correction block: x^e as exp2(e*log2(x)), seven stages.
// Depends on gcr_pkg for widths, constants and the table builder functions.
module gcr_lane
    import gcr_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 8
) (
    input  logic                  clk,
    input  logic [CHANNEL_BITS-1:0] x,
    input  logic [GAMMA_BITS-1:0] gamma,
    output logic [CHANNEL_BITS-1:0] ch_out
);

    localparam int TAB_LEN = (1 << TABLE_ADDR_BITS) + 1;
    localparam int WB      = 23 - TABLE_ADDR_BITS;   // log interpolation weight bits
    localparam int EB      = 16 - TABLE_ADDR_BITS;   // exp interpolation weight bits
    localparam int A       = TABLE_ADDR_BITS;
    // log2(x) in signed Q.16; integer part spans about -(CHANNEL_BITS-4) to +3.
    localparam int LG_W    = 22;
    localparam int IP_W    = LG_W - 16;
    localparam int Y_W     = LG_W + GAMMA_BITS + 1;  // product, signed Q.28
    localparam int N_W     = Y_W - 28;               // integer part of the product
    localparam int S_W     = N_W + 2;                // final shift count
    localparam int SHR_MAX = 24;                     // larger right shifts give zero
    localparam int R_W     = 26;

    // Constant lookup tables, built at elaboration.
    logic [16:0] lg_rom [TAB_LEN];
    logic [17:0] ex_rom [TAB_LEN];

    for (genvar g = 0; g < TAB_LEN; g++) begin : g_rom
        localparam logic [16:0] LG_VAL = lg_entry(g, TABLE_ADDR_BITS);
        localparam logic [17:0] EX_VAL = ex_entry(g, TABLE_ADDR_BITS);
        assign lg_rom[g] = LG_VAL;
        assign ex_rom[g] = EX_VAL;
    end

    // Stage registers.
    logic [4:0]            p1_reg, p1_next, p2_reg, p2_next;
    logic [A-1:0]          idx1_reg, idx1_next;
    logic [WB-1:0]         w1_reg, w1_next, w2_reg, w2_next;
    logic                  z1_reg, z1_next, z2_reg, z2_next, z3_reg, z3_next;
    logic                  z4_reg, z4_next, z5_reg, z5_next, z6_reg, z6_next;
    logic                  z7_reg, z7_next;
    logic [16:0]           lg_lo2_reg, lg_lo2_next, lg_df2_reg, lg_df2_next;
    logic signed [LG_W-1:0] lg3_reg, lg3_next;
    logic signed [Y_W-1:0] y4_reg, y4_next;
    logic                  sat5_reg, sat5_next, sat6_reg, sat6_next, sat7_reg, sat7_next;
    logic signed [S_W-1:0] s5_reg, s5_next, s6_reg, s6_next, s7_reg, s7_next;
    logic [A-1:0]          ei5_reg, ei5_next;
    logic [EB-1:0]         ew5_reg, ew5_next, ew6_reg, ew6_next;
    logic [17:0]           ex_lo6_reg, ex_lo6_next, ex_df6_reg, ex_df6_next;
    logic [17:0]           mm7_reg, mm7_next;

    // Combinational helpers.
    logic [23:0]           x_ext;
    logic [23:0]           m_norm;
    logic [16+WB:0]        lg_prod;
    logic [16:0]           lg_interp;
    logic [IP_W-1:0]       int_part;
    logic [N_W-1:0]        n_int;
    logic [15:0]           f_frac;
    logic [17+EB:0]        ex_prod;
    logic [4:0]            shr;
    logic [4:0]            shl;
    logic [R_W-1:0]        r_val;

    // Stage 1: leading-one detect and normalization into table index and weight.
    always_comb
    begin
        x_ext   = 24'(x);
        p1_next = '0;
        for (int i = 0; i < 24; i++) begin
            if (x_ext[i]) begin
                p1_next = 5'(i);
            end
        end
        m_norm    = x_ext << (5'd23 - p1_next);
        idx1_next = m_norm[22:WB];
        w1_next   = m_norm[WB-1:0];
        z1_next   = (x == '0);
    end

    // Stage 2: log table reads at the index and the next entry.
    always_comb
    begin
        lg_lo2_next = lg_rom[idx1_reg];
        lg_df2_next = lg_rom[(A+1)'({1'b0, idx1_reg}) + (A+1)'(1)] - lg_rom[idx1_reg];
        w2_next     = w1_reg;
        p2_next     = p1_reg;
        z2_next     = z1_reg;
    end

    // Stage 3: interpolate the log fraction and attach the exponent of x.
    always_comb
    begin
        lg_prod   = (17+WB)'(lg_df2_reg) * (17+WB)'(w2_reg);
        lg_interp = lg_lo2_reg + lg_prod[16+WB:WB];
        int_part  = IP_W'({1'b0, p2_reg}) - IP_W'(FRAC_IN);
        lg3_next  = $signed({int_part, 16'b0}) + $signed({(LG_W-17)'(0), lg_interp});
        z3_next   = z2_reg;
    end

    // Stage 4: scale the log by the exponent, both operands sign-extended to full width.
    always_comb
    begin
        y4_next = Y_W'(lg3_reg) * Y_W'($signed({1'b0, gamma}));
        z4_next = z3_reg;
    end

    // Stage 5: floor to Q.16, split into integer part and exp table index and weight.
    always_comb
    begin
        sat5_next = ~y4_reg[Y_W-1];
        n_int     = y4_reg[Y_W-1:28];
        f_frac    = y4_reg[27:12];
        ei5_next  = f_frac[15:EB];
        ew5_next  = f_frac[EB-1:0];
        s5_next   = $signed(S_W'(16 - CHANNEL_BITS)) - $signed({{2{n_int[N_W-1]}}, n_int});
        z5_next   = z4_reg;
    end

    // Stage 6: exp table reads.
    always_comb
    begin
        ex_lo6_next = ex_rom[ei5_reg];
        ex_df6_next = ex_rom[(A+1)'({1'b0, ei5_reg}) + (A+1)'(1)] - ex_rom[ei5_reg];
        ew6_next    = ew5_reg;
        sat6_next   = sat5_reg;
        s6_next     = s5_reg;
        z6_next     = z5_reg;
    end

    // Stage 7: interpolate the Q1.16 mantissa.
    always_comb
    begin
        ex_prod   = (18+EB)'(ex_df6_reg) * (18+EB)'(ew6_reg);
        mm7_next  = ex_lo6_reg + ex_prod[17+EB:EB];
        sat7_next = sat6_reg;
        s7_next   = s6_reg;
        z7_next   = z6_reg;
    end

    // Output: scale by the power of two with round half up, then clamp.
    always_comb
    begin
        shr   = s7_reg[4:0];
        shl   = 5'(-s7_reg);
        r_val = '0;
        if (s7_reg > $signed(S_W'(SHR_MAX))) begin
            r_val = '0;
        end else if (s7_reg > $signed(S_W'(0))) begin
            r_val = (R_W'(mm7_reg) + (R_W'(1) << (shr - 5'd1))) >> shr;
        end else begin
            r_val = R_W'(mm7_reg) << shl;
        end

        if (z7_reg) begin
            ch_out = '0;
        end else if (sat7_reg) begin
            ch_out = '1;
        end else if (r_val > R_W'({CHANNEL_BITS{1'b1}})) begin
            ch_out = '1;
        end else begin
            ch_out = r_val[CHANNEL_BITS-1:0];
        end
    end

    // Pipeline registers; all payload, so no reset.
    always_ff @(posedge clk)
    begin
        p1_reg     <= p1_next;
        idx1_reg   <= idx1_next;
        w1_reg     <= w1_next;
        z1_reg     <= z1_next;
        lg_lo2_reg <= lg_lo2_next;
        lg_df2_reg <= lg_df2_next;
        w2_reg     <= w2_next;
        p2_reg     <= p2_next;
        z2_reg     <= z2_next;
        lg3_reg    <= lg3_next;
        z3_reg     <= z3_next;
        y4_reg     <= y4_next;
        z4_reg     <= z4_next;
        sat5_reg   <= sat5_next;
        s5_reg     <= s5_next;
        ei5_reg    <= ei5_next;
        ew5_reg    <= ew5_next;
        z5_reg     <= z5_next;
        ex_lo6_reg <= ex_lo6_next;
        ex_df6_reg <= ex_df6_next;
        ew6_reg    <= ew6_next;
        sat6_reg   <= sat6_next;
        s6_reg     <= s6_next;
        z6_reg     <= z6_next;
        mm7_reg    <= mm7_next;
        sat7_reg   <= sat7_next;
        s7_reg     <= s7_next;
        z7_reg     <= z7_next;
    end

endmodule

### src/gcr_merge.sv
// Merge stage of the gamma correction block: packs the three lane results into one
// registered output pixel with its strobe. Depends on gcr_pkg for the result type.
module gcr_merge
    import gcr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  logic [CHANNEL_BITS-1:0] red_lane,
    input  logic [CHANNEL_BITS-1:0] green_lane,
    input  logic [CHANNEL_BITS-1:0] blue_lane,
    output logic                    done,
    output pixel_out_t              result
);

    logic       done_reg, done_next;
    pixel_out_t result_reg, result_next;

    // Combine the lanes into one result transfer.
    always_comb
    begin
        done_next             = valid_in;
        result_next.red_out   = red_lane;
        result_next.green_out = green_lane;
        result_next.blue_out  = blue_lane;
    end

    // The strobe is control state and resets; the pixel is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### src/gamma_correct_rgb.sv
// Top level of the power-law gamma correction block; uses gcr_pkg, gcr_lane, gcr_merge.
// Usage:
//   Input: a pixel transfer happens at a rising edge with start high and busy low.
//   busy is always low, so a new pixel may be sent in every cycle.
//   Output: done is high for exactly one cycle with the corrected pixel on result.
//   The receiver cannot stall; results must be taken in the cycle they appear.
//   Timing: the accepted pixel passes the seven lane stage registers and then the
//   merge register, which raises done. Throughput is one pixel per clock.
//   The rate is set by three independent channel lanes, each a seven-stage pipeline
//   of two table lookups, two interpolation multipliers and one exponent multiplier.
//   Configuration: gamma_wdata is written into the exponent register (U4.12) at an
//   edge with gamma_we high; write it only while no pixel is in flight.
//   Reset (rst_n low, asynchronous) clears the pipeline valid bits and done and
//   loads the exponent register with the value for gamma 2.2; pixels in flight
//   at reset are dropped.
module gamma_correct_rgb
    import gcr_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pixel_in_t             pixel,
    input  logic                  gamma_we,
    input  logic [GAMMA_BITS-1:0] gamma_wdata,
    output logic                  done,
    output pixel_out_t            result
);

    localparam int VP_LEN = GCR_LATENCY - 1;

    logic [GAMMA_BITS-1:0]   gamma_reg, gamma_next;
    logic [VP_LEN-1:0]       valid_reg, valid_next;
    logic [CHANNEL_BITS-1:0] red_lane, green_lane, blue_lane;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Exponent register and valid tracking along the lane stages.
    always_comb
    begin
        gamma_next = gamma_we ? gamma_wdata : gamma_reg;
        valid_next = {valid_reg[VP_LEN-2:0], start & ~busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gamma_reg <= GAMMA_RESET;
            valid_reg <= '0;
        end else begin
            gamma_reg <= gamma_next;
            valid_reg <= valid_next;
        end
    end

    // One lane per color channel.
    gcr_lane #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_lane_red (
        .clk    (clk),
        .x      (pixel.red_in),
        .gamma  (gamma_reg),
        .ch_out (red_lane)
    );

    gcr_lane #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_lane_green (
        .clk    (clk),
        .x      (pixel.green_in),
        .gamma  (gamma_reg),
        .ch_out (green_lane)
    );

    gcr_lane #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_lane_blue (
        .clk    (clk),
        .x      (pixel.blue_in),
        .gamma  (gamma_reg),
        .ch_out (blue_lane)
    );

    // Output register and strobe.
    gcr_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (valid_reg[VP_LEN-1]),
        .red_lane   (red_lane),
        .green_lane (green_lane),
        .blue_lane  (blue_lane),
        .done       (done),
        .result     (result)
    );

endmodule

### src/gcr_checker.sv
// Port-level checks for the gamma correction block, attached to the top level by bind.
// Depends on gcr_pkg for the pixel types, widths and the pipeline latency.
module gcr_checker
    import gcr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input pixel_in_t             pixel,
    input logic                  done,
    input pixel_out_t            result
);

    // The pipeline takes a pixel in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a pipeline that never stalls");

    // Every accepted pixel gives a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##GCR_LATENCY done)
        else $error("accepted pixel produced no result");

    // No result without a pixel accepted the latency earlier.
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, GCR_LATENCY))
        else $error("result without an accepted pixel");

    // A black red channel stays black whatever the exponent.
    a_zero_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (start && pixel.red_in == '0) |-> ##GCR_LATENCY (result.red_out == '0))
        else $error("zero red channel did not give zero");

    // A green channel at or above 1.0 saturates to full scale.
    a_bright_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (start && pixel.green_in[CHANNEL_BITS-1:FRAC_IN] != '0)
        |-> ##GCR_LATENCY (result.green_out == '1))
        else $error("green channel of 1.0 or more did not saturate");

endmodule

bind gamma_correct_rgb gcr_checker u_gcr_checker (.*);
